[rtl/core/bbps_pkg.sv]
// ----------------------------------------------------------------------------
// bbps_pkg
// Shared types, constants and helpers for the bouncing block physics step.
// ----------------------------------------------------------------------------
package bbps_pkg;

  // Fixed point fraction bits of positions and velocities
  localparam int FRAC_BITS = 8;

  // Field widths
  localparam int COORD_W  = 24;
  localparam int REST_W   = 9;
  localparam int GRAV_W   = 13;
  localparam int FRIC_W   = 12;
  localparam int BLOCK_W  = 10;
  localparam int ARENA_W  = 12;

  // Configuration channel
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Stream payload widths
  localparam int S_TDATA_W = 4 * COORD_W;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 152;

  // Saturation helper input width
  localparam int SAT_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESTITUTION    = 3'd0,
    CFG_GRAVITY_Y      = 3'd1,
    CFG_FLOOR_FRICTION = 3'd2,
    CFG_BLOCK_WIDTH    = 3'd3,
    CFG_BLOCK_HEIGHT   = 3'd4,
    CFG_ARENA_WIDTH    = 3'd5,
    CFG_ARENA_HEIGHT   = 3'd6
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [REST_W-1:0]         RST_RESTITUTION    = 9'd205;
  localparam logic signed [GRAV_W-1:0]  RST_GRAVITY_Y      = 13'sd0;
  localparam logic [FRIC_W-1:0]         RST_FLOOR_FRICTION = 12'd18;
  localparam logic [BLOCK_W-1:0]        RST_BLOCK_WIDTH    = 10'd20;
  localparam logic [BLOCK_W-1:0]        RST_BLOCK_HEIGHT   = 10'd20;
  localparam logic [ARENA_W-1:0]        RST_ARENA_WIDTH    = 12'd800;
  localparam logic [ARENA_W-1:0]        RST_ARENA_HEIGHT   = 12'd450;

  typedef struct packed {
    logic [REST_W-1:0]        restitution;
    logic signed [GRAV_W-1:0] gravity_y;
    logic [FRIC_W-1:0]        floor_friction;
    logic [BLOCK_W-1:0]       block_width;
    logic [BLOCK_W-1:0]       block_height;
    logic [ARENA_W-1:0]       arena_width;
    logic [ARENA_W-1:0]       arena_height;
  } cfg_t;

  typedef struct packed {
    logic                      grab;
    logic                      take_delta;
    logic signed [COORD_W-1:0] pointer_x;
    logic signed [COORD_W-1:0] pointer_y;
    logic signed [COORD_W-1:0] delta_x;
    logic signed [COORD_W-1:0] delta_y;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] speed_x;
    logic signed [COORD_W-1:0] speed_y;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic                      hit_side;
    logic                      hit_floor_or_top;
  } result_t;

  localparam logic signed [SAT_W-1:0] COORD_MAX = 40'sd8388607;
  localparam logic signed [SAT_W-1:0] COORD_MIN = -40'sd8388608;

  // Clip a wide signed value to the 24 bit coordinate range
  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/bbps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bbps_cfg_regs
// Configuration register file, written through an index/data channel.
// ----------------------------------------------------------------------------
module bbps_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [bbps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bbps_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output bbps_pkg::cfg_t                   cfg_o
);

  bbps_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write request
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (bbps_pkg::cfg_idx_e'(cfg_index_i))
        bbps_pkg::CFG_RESTITUTION:
          cfg_d.restitution = cfg_data_i[bbps_pkg::REST_W-1:0];
        bbps_pkg::CFG_GRAVITY_Y:
          cfg_d.gravity_y = $signed(cfg_data_i[bbps_pkg::GRAV_W-1:0]);
        bbps_pkg::CFG_FLOOR_FRICTION:
          cfg_d.floor_friction = cfg_data_i[bbps_pkg::FRIC_W-1:0];
        bbps_pkg::CFG_BLOCK_WIDTH:
          cfg_d.block_width = cfg_data_i[bbps_pkg::BLOCK_W-1:0];
        bbps_pkg::CFG_BLOCK_HEIGHT:
          cfg_d.block_height = cfg_data_i[bbps_pkg::BLOCK_W-1:0];
        bbps_pkg::CFG_ARENA_WIDTH:
          cfg_d.arena_width = cfg_data_i[bbps_pkg::ARENA_W-1:0];
        bbps_pkg::CFG_ARENA_HEIGHT:
          cfg_d.arena_height = cfg_data_i[bbps_pkg::ARENA_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.restitution    <= bbps_pkg::RST_RESTITUTION;
      cfg_q.gravity_y      <= bbps_pkg::RST_GRAVITY_Y;
      cfg_q.floor_friction <= bbps_pkg::RST_FLOOR_FRICTION;
      cfg_q.block_width    <= bbps_pkg::RST_BLOCK_WIDTH;
      cfg_q.block_height   <= bbps_pkg::RST_BLOCK_HEIGHT;
      cfg_q.arena_width    <= bbps_pkg::RST_ARENA_WIDTH;
      cfg_q.arena_height   <= bbps_pkg::RST_ARENA_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/bbps_physics.sv]
// ----------------------------------------------------------------------------
// bbps_physics
// One frame tick: grab handling, wall reflection, clamp, friction, gravity
// and integration, all saturating. Pure combinational logic.
// ----------------------------------------------------------------------------
module bbps_physics #(
  parameter int FracBits = bbps_pkg::FRAC_BITS
) (
  input  bbps_pkg::cfg_t    cfg_i,
  input  bbps_pkg::item_t   item_i,
  input  bbps_pkg::state_t  state_i,
  output bbps_pkg::state_t  state_o,
  output bbps_pkg::result_t res_o
);

  localparam int CW    = bbps_pkg::COORD_W;
  localparam int SW    = bbps_pkg::SAT_W;
  localparam int DimW  = bbps_pkg::ARENA_W + FracBits;
  localparam int ExtW  = ((DimW > CW) ? DimW : CW) + 2;
  localparam int ProdW = CW + bbps_pkg::REST_W + 2;

  logic signed [ExtW-1:0]  hw, hh, aw, ah, px, py, pxc, pyc;
  logic                    left, right, top, floor_hit, hx, hy;
  logic signed [bbps_pkg::REST_W:0] rest_s;
  logic signed [ProdW-1:0] prod_x, prod_y, refl_x, refl_y;
  logic signed [CW-1:0]    vxr, vyr, vxn, vyn, pxs, pys, pos_xn, pos_yn;
  logic signed [CW:0]      vx_w, fric_w, vx_dec;
  bbps_pkg::state_t        nxt;

  // Arena geometry in fixed point
  assign hw = $signed(ExtW'(cfg_i.block_width) << (FracBits - 1));
  assign hh = $signed(ExtW'(cfg_i.block_height) << (FracBits - 1));
  assign aw = $signed(ExtW'(cfg_i.arena_width) << FracBits);
  assign ah = $signed(ExtW'(cfg_i.arena_height) << FracBits);
  assign px = ExtW'(state_i.pos_x);
  assign py = ExtW'(state_i.pos_y);

  // Wall overlap tests, on the position before clamping
  assign left      = (px - hw) < 0;
  assign right     = (px + hw) > aw;
  assign top       = (py - hh) < 0;
  assign floor_hit = (py + hh) > ah;
  assign hx        = left || right;
  assign hy        = top || floor_hit;

  // Reflection: round(-(v * e) / 256), ties toward plus infinity
  assign rest_s = $signed({1'b0, cfg_i.restitution});
  assign prod_x = ProdW'(state_i.vel_x) * ProdW'(rest_s);
  assign prod_y = ProdW'(state_i.vel_y) * ProdW'(rest_s);
  assign refl_x = (ProdW'(128) - prod_x) >>> 8;
  assign refl_y = (ProdW'(128) - prod_y) >>> 8;
  assign vxr = hx ? bbps_pkg::sat24(SW'(refl_x)) : state_i.vel_x;
  assign vyr = hy ? bbps_pkg::sat24(SW'(refl_y)) : state_i.vel_y;

  // Clamp inside the arena, left and top win
  always_comb begin
    if (left) begin
      pxc = hw;
    end else if (right) begin
      pxc = aw - hw;
    end else begin
      pxc = px;
    end
    if (top) begin
      pyc = hh;
    end else if (floor_hit) begin
      pyc = ah - hh;
    end else begin
      pyc = py;
    end
  end
  assign pxs = bbps_pkg::sat24(SW'(pxc));
  assign pys = bbps_pkg::sat24(SW'(pyc));

  // Floor friction pulls x velocity toward zero without crossing it
  assign vx_w   = (CW + 1)'(vxr);
  assign fric_w = $signed((CW + 1)'(cfg_i.floor_friction));
  always_comb begin
    vx_dec = vx_w;
    if (floor_hit && !top) begin
      if (vxr > 0) begin
        vx_dec = ((vx_w - fric_w) < 0) ? '0 : (vx_w - fric_w);
      end else if (vxr < 0) begin
        vx_dec = ((vx_w + fric_w) > 0) ? '0 : (vx_w + fric_w);
      end
    end
  end
  assign vxn = vx_dec[CW-1:0];
  assign vyn = bbps_pkg::sat24(SW'(vyr) + SW'(cfg_i.gravity_y));

  // Integrate
  assign pos_xn = bbps_pkg::sat24(SW'(pxs) + SW'(vxn));
  assign pos_yn = bbps_pkg::sat24(SW'(pys) + SW'(vyn));

  // Grabbed tick or physics tick
  always_comb begin
    if (item_i.grab) begin
      nxt.pos_x = item_i.pointer_x;
      nxt.pos_y = item_i.pointer_y;
      nxt.vel_x = item_i.take_delta ? item_i.delta_x : state_i.vel_x;
      nxt.vel_y = item_i.take_delta ? item_i.delta_y : state_i.vel_y;
    end else begin
      nxt.pos_x = pos_xn;
      nxt.pos_y = pos_yn;
      nxt.vel_x = vxn;
      nxt.vel_y = vyn;
    end
  end

  assign state_o = nxt;

  // Result fields
  assign res_o.center_x         = nxt.pos_x;
  assign res_o.center_y         = nxt.pos_y;
  assign res_o.speed_x          = nxt.vel_x;
  assign res_o.speed_y          = nxt.vel_y;
  assign res_o.rect_left        = bbps_pkg::sat24(SW'(nxt.pos_x) - SW'(hw));
  assign res_o.rect_top         = bbps_pkg::sat24(SW'(nxt.pos_y) - SW'(hh));
  assign res_o.hit_side         = !item_i.grab && hx;
  assign res_o.hit_floor_or_top = !item_i.grab && hy;

endmodule

[rtl/core/box_bounce_physics_step.sv]
// ----------------------------------------------------------------------------
// box_bounce_physics_step
// Bouncing block with restitution, one frame tick per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick request: pointer position, pointer delta and the
//   grab / take_delta flags. m_axis returns one result per request: new
//   center, velocity, rect corner and the wall hit flags.
//   cfg_* writes one register by index; it is always ready and must only be
//   used while no request is in flight.
// Timing:
//   A request is taken into the input register; the physics step runs
//   between that register and the result register. One request per cycle
//   is sustained while m_axis_tready stays high; the step updates the block
//   state in the same cycle as the result register, so ticks chain back to back.
// Reset:
//   Position and velocity clear to zero, registers take their default values,
//   both pipeline registers empty.
// Stall:
//   While m_axis_tready is low the result holds; one more request is still
//   taken into the input register if it is empty; then s_axis_tready drops.
// ----------------------------------------------------------------------------
module box_bounce_physics_step #(
  parameter int FRAC_BITS = bbps_pkg::FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Tick requests
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [23:0] pointer_x, [47:24] pointer_y, [71:48] delta_x, [95:72] delta_y
  input  logic [bbps_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] grab, [1] take_delta
  input  logic [bbps_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // Results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [23:0] center_x, [47:24] center_y, [71:48] speed_x, [95:72] speed_y,
  // [119:96] rect_left, [143:120] rect_top, [144] hit_side,
  // [145] hit_floor_or_top, [151:146] zero
  output logic [bbps_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // Configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bbps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bbps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int CW = bbps_pkg::COORD_W;

  bbps_pkg::cfg_t    cfg;
  bbps_pkg::item_t   in_q;
  bbps_pkg::state_t  st_q, st_nxt;
  bbps_pkg::result_t res_d, res_q;
  logic              in_vld_q, in_vld_d, out_vld_q, out_vld_d;
  logic              out_free, s_acc, step;

  assign cfg_ready_o = 1'b1;

  bbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bbps_physics #(
    .FracBits (FRAC_BITS)
  ) u_phys (
    .cfg_i   (cfg),
    .item_i  (in_q),
    .state_i (st_q),
    .state_o (st_nxt),
    .res_o   (res_d)
  );

  // Handshake: input register drains into the result register
  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign step          = in_vld_q && out_free;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (out_free) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_free ? in_vld_q : out_vld_q;
  end

  // Control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (step) begin
        st_q <= st_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q.grab       <= s_axis_tuser[0];
      in_q.take_delta <= s_axis_tuser[1];
      in_q.pointer_x  <= $signed(s_axis_tdata[CW-1:0]);
      in_q.pointer_y  <= $signed(s_axis_tdata[2*CW-1:CW]);
      in_q.delta_x    <= $signed(s_axis_tdata[3*CW-1:2*CW]);
      in_q.delta_y    <= $signed(s_axis_tdata[4*CW-1:3*CW]);
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, res_q.hit_floor_or_top, res_q.hit_side,
                          res_q.rect_top, res_q.rect_left,
                          res_q.speed_y, res_q.speed_x,
                          res_q.center_y, res_q.center_x};

endmodule

[rtl/core/bbps_checker.sv]
// ----------------------------------------------------------------------------
// bbps_checker
// Port level checks for the physics step, bound to the top level.
// ----------------------------------------------------------------------------
module bbps_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bbps_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // With the result register empty, a request is always taken
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request blocked with empty output");

  // A new result rises only after a request has been accepted and held in the input register
  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a request");

endmodule

bind box_bounce_physics_step bbps_checker u_bbps_checker (.*);
